[rtl/tlmde_pkg.sv]
// Shared types, constants and register map of the three-line modulated delay ensemble.
package tlmde_pkg;

  localparam int LINE_DEPTH_DEF = 2048;
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int TAP_COUNT      = 3;
  localparam int TAP_W          = 2;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 32;
  localparam int DEPTH_UNITY    = 32768;
  localparam logic [31:0] PHASE_STEP = 32'h5555_5555;

  localparam logic [24:0] TREMOLO_INC_RST   = 25'd521650;
  localparam logic [24:0] CHORUS_INC_RST    = 25'd51898;
  localparam logic [15:0] TREMOLO_DEPTH_RST = 16'd16384;
  localparam logic [15:0] CHORUS_DEPTH_RST  = 16'd16384;
  localparam logic [19:0] DELAY_CENTER_RST  = 20'd61440;
  localparam logic [19:0] DELAY_VAR_RST     = 20'd24576;
  localparam logic [11:0] LINE_LENGTH_RST   = 12'd2048;
  localparam logic        ENABLE_RST        = 1'b1;

  typedef enum logic [2:0] {
    REG_TREMOLO_INC   = 3'd0,
    REG_CHORUS_INC    = 3'd1,
    REG_TREMOLO_DEPTH = 3'd2,
    REG_CHORUS_DEPTH  = 3'd3,
    REG_DELAY_CENTER  = 3'd4,
    REG_DELAY_VAR     = 3'd5,
    REG_LINE_LENGTH   = 3'd6,
    REG_ENABLE        = 3'd7
  } tlmde_reg_t;

  typedef struct packed {
    logic [24:0] tremolo_increment;
    logic [24:0] chorus_increment;
    logic [15:0] tremolo_depth;
    logic [15:0] chorus_depth;
    logic [19:0] delay_center;
    logic [19:0] delay_variation;
    logic [11:0] line_length;
    logic        ensemble_enable;
  } tlmde_cfg_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_WRITE, ST_K1, ST_K2, ST_S1, ST_S2, ST_SUM, ST_DL,
    ST_CLAMP, ST_POS, ST_IDX, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_COEF, ST_M1,
    ST_ADDB, ST_MT1, ST_ADDC, ST_MT2, ST_FIN, ST_DONE
  } tlmde_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_WRITE, OP_IDX_TREM, OP_IDX_CHOR,
    OP_SINE_TREM, OP_SINE_CHOR, OP_MOD_SUM, OP_DELAY_MUL, OP_CLAMP, OP_POS,
    OP_INDEX, OP_READ, OP_COEF, OP_MUL_A, OP_ADD_B, OP_MUL_T, OP_ADD_C,
    OP_FIN, OP_OUT
  } tlmde_op_t;

  typedef struct packed {
    tlmde_op_t        op;
    logic [TAP_W-1:0] tap;
  } tlmde_cmd_t;

  typedef struct packed {
    logic clear_last;
  } tlmde_stat_t;

endpackage

[rtl/three_line_modulated_delay_ensemble.sv]
// Top level of the three-line modulated delay ensemble.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_dry_sample, in_filtered_sample
//   out_     output     out_valid / out_ready  out_left_sample, out_right_sample
//   cfg      apb        psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// An item passes from transfer in to result valid through one store write, then
// 20 steps per tap for three taps on the shared multiplier and the single store
// read port, then the load of the result register.
// After reset a clearing pass zeroes every store entry; no input transfer is
// taken until it ends. A stalled result holds in its register and the
// sequencer waits in its last step until that register is free.
module three_line_modulated_delay_ensemble #(
  parameter int LINE_DEPTH       = tlmde_pkg::LINE_DEPTH_DEF,
  parameter int SINE_TABLE_DEPTH = tlmde_pkg::SINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_dry_sample,
  input  logic signed [15:0]            in_filtered_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [17:0]            out_left_sample,
  output logic signed [17:0]            out_right_sample,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlmde_pkg::PADDR_W-1:0] paddr,
  input  logic [tlmde_pkg::PDATA_W-1:0] pwdata,
  output logic [tlmde_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  tlmde_pkg::tlmde_cfg_t  cfg;
  tlmde_pkg::tlmde_cmd_t  cmd;
  tlmde_pkg::tlmde_stat_t stat;

  tlmde_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlmde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlmde_dp #(
    .LINE_DEPTH       (LINE_DEPTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg                (cfg),
    .in_dry_sample      (in_dry_sample),
    .in_filtered_sample (in_filtered_sample),
    .out_left_sample    (out_left_sample),
    .out_right_sample   (out_right_sample)
  );

endmodule

[rtl/tlmde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tlmde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tlmde_regs.sv]
// Configuration register file behind the APB-style port.
module tlmde_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlmde_pkg::PADDR_W-1:0]   paddr,
  input  logic [tlmde_pkg::PDATA_W-1:0]   pwdata,
  output logic [tlmde_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output tlmde_pkg::tlmde_cfg_t           cfg
);

  tlmde_pkg::tlmde_cfg_t cfg_r;
  tlmde_pkg::tlmde_cfg_t cfg_nxt;
  tlmde_pkg::tlmde_reg_t reg_sel;
  logic                  wr_en;

  assign reg_sel = tlmde_pkg::tlmde_reg_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        tlmde_pkg::REG_TREMOLO_INC:   cfg_nxt.tremolo_increment = pwdata[24:0];
        tlmde_pkg::REG_CHORUS_INC:    cfg_nxt.chorus_increment  = pwdata[24:0];
        tlmde_pkg::REG_TREMOLO_DEPTH: cfg_nxt.tremolo_depth     = pwdata[15:0];
        tlmde_pkg::REG_CHORUS_DEPTH:  cfg_nxt.chorus_depth      = pwdata[15:0];
        tlmde_pkg::REG_DELAY_CENTER:  cfg_nxt.delay_center      = pwdata[19:0];
        tlmde_pkg::REG_DELAY_VAR:     cfg_nxt.delay_variation   = pwdata[19:0];
        tlmde_pkg::REG_LINE_LENGTH:   cfg_nxt.line_length       = pwdata[11:0];
        tlmde_pkg::REG_ENABLE:        cfg_nxt.ensemble_enable   = pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tlmde_pkg::REG_TREMOLO_INC:   prdata = 32'(cfg_r.tremolo_increment);
      tlmde_pkg::REG_CHORUS_INC:    prdata = 32'(cfg_r.chorus_increment);
      tlmde_pkg::REG_TREMOLO_DEPTH: prdata = 32'(cfg_r.tremolo_depth);
      tlmde_pkg::REG_CHORUS_DEPTH:  prdata = 32'(cfg_r.chorus_depth);
      tlmde_pkg::REG_DELAY_CENTER:  prdata = 32'(cfg_r.delay_center);
      tlmde_pkg::REG_DELAY_VAR:     prdata = 32'(cfg_r.delay_variation);
      tlmde_pkg::REG_LINE_LENGTH:   prdata = 32'(cfg_r.line_length);
      tlmde_pkg::REG_ENABLE:        prdata = 32'(cfg_r.ensemble_enable);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tremolo_increment <= tlmde_pkg::TREMOLO_INC_RST;
      cfg_r.chorus_increment  <= tlmde_pkg::CHORUS_INC_RST;
      cfg_r.tremolo_depth     <= tlmde_pkg::TREMOLO_DEPTH_RST;
      cfg_r.chorus_depth      <= tlmde_pkg::CHORUS_DEPTH_RST;
      cfg_r.delay_center      <= tlmde_pkg::DELAY_CENTER_RST;
      cfg_r.delay_variation   <= tlmde_pkg::DELAY_VAR_RST;
      cfg_r.line_length       <= tlmde_pkg::LINE_LENGTH_RST;
      cfg_r.ensemble_enable   <= tlmde_pkg::ENABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/tlmde_ctrl.sv]
// Sequencer that steps the datapath through one item, tap by tap.
module tlmde_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  tlmde_pkg::tlmde_stat_t stat,
  output tlmde_pkg::tlmde_cmd_t  cmd
);

  tlmde_pkg::tlmde_state_t             state_r;
  tlmde_pkg::tlmde_state_t             state_nxt;
  logic [tlmde_pkg::TAP_W-1:0]         tap_r;
  logic [tlmde_pkg::TAP_W-1:0]         tap_nxt;
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic                                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlmde_pkg::ST_CLEAR: if (stat.clear_last) state_nxt = tlmde_pkg::ST_IDLE;
      tlmde_pkg::ST_IDLE:  if (in_valid) state_nxt = tlmde_pkg::ST_WRITE;
      tlmde_pkg::ST_WRITE: state_nxt = tlmde_pkg::ST_K1;
      tlmde_pkg::ST_K1:    state_nxt = tlmde_pkg::ST_K2;
      tlmde_pkg::ST_K2:    state_nxt = tlmde_pkg::ST_S1;
      tlmde_pkg::ST_S1:    state_nxt = tlmde_pkg::ST_S2;
      tlmde_pkg::ST_S2:    state_nxt = tlmde_pkg::ST_SUM;
      tlmde_pkg::ST_SUM:   state_nxt = tlmde_pkg::ST_DL;
      tlmde_pkg::ST_DL:    state_nxt = tlmde_pkg::ST_CLAMP;
      tlmde_pkg::ST_CLAMP: state_nxt = tlmde_pkg::ST_POS;
      tlmde_pkg::ST_POS:   state_nxt = tlmde_pkg::ST_IDX;
      tlmde_pkg::ST_IDX:   state_nxt = tlmde_pkg::ST_RD0;
      tlmde_pkg::ST_RD0:   state_nxt = tlmde_pkg::ST_RD1;
      tlmde_pkg::ST_RD1:   state_nxt = tlmde_pkg::ST_RD2;
      tlmde_pkg::ST_RD2:   state_nxt = tlmde_pkg::ST_RD3;
      tlmde_pkg::ST_RD3:   state_nxt = tlmde_pkg::ST_COEF;
      tlmde_pkg::ST_COEF:  state_nxt = tlmde_pkg::ST_M1;
      tlmde_pkg::ST_M1:    state_nxt = tlmde_pkg::ST_ADDB;
      tlmde_pkg::ST_ADDB:  state_nxt = tlmde_pkg::ST_MT1;
      tlmde_pkg::ST_MT1:   state_nxt = tlmde_pkg::ST_ADDC;
      tlmde_pkg::ST_ADDC:  state_nxt = tlmde_pkg::ST_MT2;
      tlmde_pkg::ST_MT2:   state_nxt = tlmde_pkg::ST_FIN;
      tlmde_pkg::ST_FIN: begin
        state_nxt = (tap_r == tlmde_pkg::TAP_LAST) ? tlmde_pkg::ST_DONE : tlmde_pkg::ST_K1;
      end
      tlmde_pkg::ST_DONE:  if (out_free) state_nxt = tlmde_pkg::ST_IDLE;
      default:             state_nxt = tlmde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == tlmde_pkg::ST_IDLE);
    cmd.tap  = tap_r;
    unique case (state_r)
      tlmde_pkg::ST_CLEAR: cmd.op = tlmde_pkg::OP_CLEAR;
      tlmde_pkg::ST_IDLE:  cmd.op = in_valid ? tlmde_pkg::OP_LOAD : tlmde_pkg::OP_NONE;
      tlmde_pkg::ST_WRITE: cmd.op = tlmde_pkg::OP_WRITE;
      tlmde_pkg::ST_K1:    cmd.op = tlmde_pkg::OP_IDX_TREM;
      tlmde_pkg::ST_K2:    cmd.op = tlmde_pkg::OP_IDX_CHOR;
      tlmde_pkg::ST_S1:    cmd.op = tlmde_pkg::OP_SINE_TREM;
      tlmde_pkg::ST_S2:    cmd.op = tlmde_pkg::OP_SINE_CHOR;
      tlmde_pkg::ST_SUM:   cmd.op = tlmde_pkg::OP_MOD_SUM;
      tlmde_pkg::ST_DL:    cmd.op = tlmde_pkg::OP_DELAY_MUL;
      tlmde_pkg::ST_CLAMP: cmd.op = tlmde_pkg::OP_CLAMP;
      tlmde_pkg::ST_POS:   cmd.op = tlmde_pkg::OP_POS;
      tlmde_pkg::ST_IDX:   cmd.op = tlmde_pkg::OP_INDEX;
      tlmde_pkg::ST_RD0,
      tlmde_pkg::ST_RD1,
      tlmde_pkg::ST_RD2,
      tlmde_pkg::ST_RD3:   cmd.op = tlmde_pkg::OP_READ;
      tlmde_pkg::ST_COEF:  cmd.op = tlmde_pkg::OP_COEF;
      tlmde_pkg::ST_M1:    cmd.op = tlmde_pkg::OP_MUL_A;
      tlmde_pkg::ST_ADDB:  cmd.op = tlmde_pkg::OP_ADD_B;
      tlmde_pkg::ST_MT1,
      tlmde_pkg::ST_MT2:   cmd.op = tlmde_pkg::OP_MUL_T;
      tlmde_pkg::ST_ADDC:  cmd.op = tlmde_pkg::OP_ADD_C;
      tlmde_pkg::ST_FIN:   cmd.op = tlmde_pkg::OP_FIN;
      tlmde_pkg::ST_DONE:  cmd.op = out_free ? tlmde_pkg::OP_OUT : tlmde_pkg::OP_NONE;
      default:             cmd.op = tlmde_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    tap_nxt = tap_r;
    if (state_r == tlmde_pkg::ST_WRITE) begin
      tap_nxt = '0;
    end else if (state_r == tlmde_pkg::ST_FIN && tap_r != tlmde_pkg::TAP_LAST) begin
      tap_nxt = tap_r + tlmde_pkg::TAP_W'(1);
    end
    if (cmd.op == tlmde_pkg::OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlmde_pkg::ST_CLEAR;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while an item is in flight");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tlmde_pkg::OP_OUT) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tlmde_pkg::OP_FIN) |-> (tap_r <= tlmde_pkg::TAP_LAST))
    else $error("tap counter out of range");
  a_rose_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tlmde_pkg::ST_DONE))
    else $error("result raised outside the done step");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tlmde_pkg::ST_CLEAR) |-> (!out_valid_r && !in_ready))
    else $error("activity during store clear");
`endif

endmodule

[rtl/tlmde_dp.sv]
// Datapath: sample store, sine table, shared multiplier and tap arithmetic.
module tlmde_dp #(
  parameter int LINE_DEPTH       = tlmde_pkg::LINE_DEPTH_DEF,
  parameter int SINE_TABLE_DEPTH = tlmde_pkg::SINE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlmde_pkg::tlmde_cmd_t  cmd,
  output tlmde_pkg::tlmde_stat_t stat,
  input  tlmde_pkg::tlmde_cfg_t  cfg,
  input  logic signed [15:0]     in_dry_sample,
  input  logic signed [15:0]     in_filtered_sample,
  output logic signed [17:0]     out_left_sample,
  output logic signed [17:0]     out_right_sample
);

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int NW  = $clog2(LINE_DEPTH + 1);
  localparam int SW  = $clog2(SINE_TABLE_DEPTH);
  localparam int PW  = NW + 9;
  localparam int CW  = (PW > 24) ? PW : 24;
  localparam int MAW = 38;
  localparam int MBW = 21;
  localparam int MPW = MAW + MBW;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [MPW-1:0] RND24 = MPW'(2 ** 24);
  localparam logic signed [MPW-1:0] RND29 = MPW'(2 ** 29);

  function automatic logic signed [15:0] sine_entry(input int unsigned k);
    logic [63:0] n;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    logic        neg;
    n   = 64'(SINE_TABLE_DEPTH);
    u   = 64'(k) * 64'd4;
    neg = 1'b0;
    if (u <= n) begin
      r = u;
    end else if (u <= 2 * n) begin
      r = 2 * n - u;
    end else if (u <= 3 * n) begin
      r   = u - 2 * n;
      neg = 1'b1;
    end else begin
      r   = 4 * n - u;
      neg = 1'b1;
    end
    x    = HALF_PI_Q30 * r / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    v = longint'((64'(sum) * 64'd32767 + 64'd536870912) >> 30);
    if (v > 32767) v = 32767;
    return neg ? 16'(-v) : 16'(v);
  endfunction

  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam logic signed [15:0] SINE_VAL = sine_entry(k);
    assign sine_rom[k] = SINE_VAL;
  end

  // control state
  logic [AW-1:0]  wi_r;
  logic [AW-1:0]  clr_cnt_r;
  logic [31:0]    trem_ph_r [tlmde_pkg::TAP_COUNT];
  logic [31:0]    chor_ph_r [tlmde_pkg::TAP_COUNT];

  // payload
  logic signed [15:0]     dry_r;
  logic signed [15:0]     filt_r;
  logic [NW-1:0]          n_r;
  logic signed [MPW-1:0]  p_r;
  logic signed [15:0]     rom_r;
  logic signed [31:0]     mod_r;
  logic signed [CW-1:0]   dl_r;
  logic signed [CW-1:0]   rp_r;
  logic [AW-1:0]          ra_r;
  logic [7:0]             mu_r;
  logic signed [15:0]     ys_r [3];
  logic signed [19:0]     a_r;
  logic signed [19:0]     b_r;
  logic signed [16:0]     c_r;
  logic signed [MAW-1:0]  t_r;
  logic signed [17:0]     left_r;
  logic signed [17:0]     right_r;
  logic signed [17:0]     out_left_r;
  logic signed [17:0]     out_right_r;

  logic signed [MAW-1:0]  ma;
  logic signed [MBW-1:0]  mb;
  logic signed [MPW-1:0]  prod;
  logic [16:0]            d1_w;
  logic [16:0]            d2_w;
  logic [SW-1:0]          k_w;
  logic [31:0]            ll_w;
  logic [NW-1:0]          n_w;
  logic [AW-1:0]          wsel_w;
  logic [AW-1:0]          wnext_w;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [15:0]            ram_wdata;
  logic [15:0]            ram_rdata;
  logic [AW-1:0]          ra_next_w;
  logic signed [MPW-1:0]  cl_sum_w;
  logic signed [MPW-1:0]  cl_sh_w;
  logic signed [CW-1:0]   raw_w;
  logic signed [CW-1:0]   hi_w;
  logic signed [CW-1:0]   dl_w;
  logic signed [CW-1:0]   rp0_w;
  logic signed [CW-1:0]   rp1_w;
  logic [NW-1:0]          i1n_w;
  logic [AW-1:0]          i1_w;
  logic signed [15:0]     y3_w;
  logic signed [19:0]     a_w;
  logic signed [19:0]     b_w;
  logic signed [16:0]     c_w;
  logic signed [MPW-1:0]  fin_sum_w;
  logic signed [MPW-1:0]  fin_sh_w;
  logic signed [21:0]     val_w;
  logic signed [17:0]     tv_w;

  assign stat.clear_last = (clr_cnt_r == AW'(LINE_DEPTH - 1));

  always_comb begin
    ll_w = 32'(cfg.line_length);
    if (ll_w < 32'd4) begin
      n_w = NW'(4);
    end else if (ll_w > 32'(LINE_DEPTH)) begin
      n_w = NW'(LINE_DEPTH);
    end else begin
      n_w = NW'(ll_w);
    end
  end

  always_comb begin
    d1_w = (cfg.tremolo_depth > 16'(tlmde_pkg::DEPTH_UNITY)) ?
           17'(tlmde_pkg::DEPTH_UNITY) : 17'(cfg.tremolo_depth);
    d2_w = (cfg.chorus_depth > 16'(tlmde_pkg::DEPTH_UNITY)) ?
           17'(tlmde_pkg::DEPTH_UNITY) : 17'(cfg.chorus_depth);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      tlmde_pkg::OP_IDX_TREM: begin
        ma = MAW'(trem_ph_r[cmd.tap]);
        mb = MBW'(SINE_TABLE_DEPTH);
      end
      tlmde_pkg::OP_IDX_CHOR: begin
        ma = MAW'(chor_ph_r[cmd.tap]);
        mb = MBW'(SINE_TABLE_DEPTH);
      end
      tlmde_pkg::OP_SINE_TREM: begin
        ma = MAW'(rom_r);
        mb = MBW'(d1_w);
      end
      tlmde_pkg::OP_SINE_CHOR: begin
        ma = MAW'(rom_r);
        mb = MBW'(d2_w);
      end
      tlmde_pkg::OP_DELAY_MUL: begin
        ma = MAW'(mod_r);
        mb = MBW'(cfg.delay_variation);
      end
      tlmde_pkg::OP_MUL_A: begin
        ma = MAW'(a_r);
        mb = MBW'(mu_r);
      end
      tlmde_pkg::OP_MUL_T: begin
        ma = t_r;
        mb = MBW'(mu_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;
  assign k_w  = p_r[32 +: SW];

  // store write and read address stepping
  always_comb begin
    wsel_w  = (NW'(wi_r) >= n_r) ? '0 : wi_r;
    wnext_w = ((NW'(wsel_w) + NW'(1)) < n_r) ? wsel_w + AW'(1) : '0;
    ra_next_w = ((NW'(ra_r) + NW'(1)) < n_r) ? ra_r + AW'(1) : '0;
    ram_we    = 1'b0;
    ram_waddr = wsel_w;
    ram_wdata = filt_r;
    if (cmd.op == tlmde_pkg::OP_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.op == tlmde_pkg::OP_WRITE) begin
      ram_we = 1'b1;
    end
  end

  tlmde_ram #(
    .WIDTH (16),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ra_r),
    .rdata (ram_rdata)
  );

  // delay and read position
  always_comb begin
    cl_sum_w = p_r + RND29;
    cl_sh_w  = cl_sum_w >>> 30;
    raw_w    = $signed(CW'(cfg.delay_center)) + $signed(cl_sh_w[CW-1:0]);
    hi_w     = $signed(CW'({n_r, 8'h00})) - $signed(CW'(512));
    if (raw_w < $signed(CW'(256))) begin
      dl_w = $signed(CW'(256));
    end else if (raw_w > hi_w) begin
      dl_w = hi_w;
    end else begin
      dl_w = raw_w;
    end
    rp0_w = $signed(CW'({wi_r, 8'h00})) - dl_r;
    rp1_w = rp0_w + $signed(CW'({n_r, 8'h00}));
    i1n_w = rp_r[8 +: NW];
    i1_w  = (i1n_w >= n_r) ? '0 : AW'(i1n_w);
  end

  // interpolation terms
  always_comb begin
    y3_w = $signed(ram_rdata);
    a_w  = (20'(y3_w) - 20'(ys_r[0])) + 20'sd3 * (20'(ys_r[1]) - 20'(ys_r[2]));
    b_w  = 20'sd2 * 20'(ys_r[0]) - 20'sd5 * 20'(ys_r[1])
         + 20'sd4 * 20'(ys_r[2]) - 20'(y3_w);
    c_w  = 17'(ys_r[2]) - 17'(ys_r[0]);
    fin_sum_w = p_r + RND24;
    fin_sh_w  = fin_sum_w >>> 25;
    val_w     = 22'(ys_r[1]) + $signed(fin_sh_w[21:0]);
    if (val_w > 22'sd32767) begin
      tv_w = 18'sd32767;
    end else if (val_w < -22'sd32768) begin
      tv_w = -18'sd32768;
    end else begin
      tv_w = 18'(val_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r      <= '0;
      clr_cnt_r <= '0;
      for (int l = 0; l < tlmde_pkg::TAP_COUNT; l++) begin
        trem_ph_r[l] <= tlmde_pkg::PHASE_STEP * 32'(l);
        chor_ph_r[l] <= tlmde_pkg::PHASE_STEP * 32'(l);
      end
    end else begin
      if (cmd.op == tlmde_pkg::OP_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.op == tlmde_pkg::OP_WRITE) begin
        wi_r <= wnext_w;
      end
      if (cmd.op == tlmde_pkg::OP_FIN) begin
        trem_ph_r[cmd.tap] <= trem_ph_r[cmd.tap] + 32'(cfg.tremolo_increment);
        chor_ph_r[cmd.tap] <= chor_ph_r[cmd.tap] + 32'(cfg.chorus_increment);
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= prod;
    rom_r <= ({1'b0, k_w} < (SW+1)'(SINE_TABLE_DEPTH)) ? sine_rom[k_w] : sine_rom[0];
    unique case (cmd.op)
      tlmde_pkg::OP_LOAD: begin
        dry_r  <= in_dry_sample;
        filt_r <= in_filtered_sample;
        n_r    <= n_w;
      end
      tlmde_pkg::OP_SINE_CHOR: mod_r <= p_r[31:0];
      tlmde_pkg::OP_MOD_SUM:   mod_r <= mod_r + p_r[31:0];
      tlmde_pkg::OP_CLAMP:     dl_r <= dl_w;
      tlmde_pkg::OP_POS:       rp_r <= rp0_w[CW-1] ? rp1_w : rp0_w;
      tlmde_pkg::OP_INDEX: begin
        ra_r <= (i1_w == '0) ? AW'(n_r - NW'(1)) : i1_w - AW'(1);
        mu_r <= rp_r[7:0];
      end
      tlmde_pkg::OP_READ: begin
        ys_r[0] <= ys_r[1];
        ys_r[1] <= ys_r[2];
        ys_r[2] <= $signed(ram_rdata);
        ra_r    <= ra_next_w;
      end
      tlmde_pkg::OP_COEF: begin
        a_r <= a_w;
        b_r <= b_w;
        c_r <= c_w;
      end
      tlmde_pkg::OP_ADD_B: t_r <= p_r[MAW-1:0] + (MAW'(b_r) <<< 8);
      tlmde_pkg::OP_ADD_C: t_r <= p_r[MAW-1:0] + (MAW'(c_r) <<< 16);
      tlmde_pkg::OP_FIN: begin
        unique case (cmd.tap)
          2'd0: begin
            left_r  <= tv_w;
            right_r <= tv_w;
          end
          2'd1: begin
            left_r  <= left_r + tv_w;
            right_r <= right_r - tv_w;
          end
          default: begin
            left_r  <= left_r - tv_w;
            right_r <= right_r - tv_w;
          end
        endcase
      end
      tlmde_pkg::OP_OUT: begin
        out_left_r  <= cfg.ensemble_enable ? left_r : 18'(dry_r);
        out_right_r <= cfg.ensemble_enable ? right_r : 18'(dry_r);
      end
      default: begin
      end
    endcase
  end

  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

endmodule
